// ----- src/escdec_pkg.sv -----
package escdec_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX1   = 2'd2,
    MODE_HEX2   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [7:0] ESCAPE_RESET = 8'h5C;

  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_X = 8'h78;

  localparam logic [7:0] CODE_NUL = 8'h00;
  localparam logic [7:0] CODE_TAB = 8'h09;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_CR  = 8'h0D;

  typedef struct packed {
    logic       has_result;
    logic [7:0] data;
    kind_t      kind;
  } result_t;

  typedef struct packed {
    mode_t mode;
  } status_t;

  // returns {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [7:0] v;
    logic       ok;
    v  = 8'd0;
    ok = 1'b1;
    if (ch inside {[8'h30:8'h39]}) begin
      v = ch - 8'h30;
    end else if (ch inside {[8'h61:8'h66]}) begin
      v = ch - 8'h57;
    end else if (ch inside {[8'h41:8'h46]}) begin
      v = ch - 8'h37;
    end else begin
      ok = 1'b0;
    end
    return {ok, v[3:0]};
  endfunction

endpackage

// ----- src/escdec_decode.sv -----
module escdec_decode import escdec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] escape_byte,
  input  logic       item_valid,
  input  logic [7:0] item_byte,
  input  logic       item_end,
  input  logic       advance,
  output result_t    res,
  output status_t    status
);

  mode_t      mode, mode_next;
  logic [3:0] first_value, first_value_next;
  logic       first_hex, first_hex_next;
  logic [4:0] hex;

  assign hex = hex_decode(item_byte);
  assign status.mode = mode;

  // next state
  always_comb begin
    mode_next        = mode;
    first_value_next = first_value;
    first_hex_next   = first_hex;
    if (item_end) begin
      mode_next        = MODE_NORMAL;
      first_value_next = 4'd0;
      first_hex_next   = 1'b0;
    end else begin
      case (mode)
        MODE_NORMAL: begin
          if (item_byte == escape_byte) mode_next = MODE_ESCAPE;
        end
        MODE_ESCAPE: begin
          mode_next = (item_byte == CH_X) ? MODE_HEX1 : MODE_NORMAL;
        end
        MODE_HEX1: begin
          mode_next        = MODE_HEX2;
          first_hex_next   = hex[4];
          first_value_next = hex[3:0];
        end
        MODE_HEX2: begin
          mode_next        = MODE_NORMAL;
          first_value_next = 4'd0;
          first_hex_next   = 1'b0;
        end
        default: mode_next = MODE_NORMAL;
      endcase
    end
  end

  // result
  always_comb begin
    res.has_result = 1'b0;
    res.data       = 8'd0;
    res.kind       = KIND_CHAR;
    if (item_end) begin
      res.has_result = 1'b1;
      res.kind       = (mode == MODE_NORMAL) ? KIND_END : KIND_ERROR;
    end else begin
      case (mode)
        MODE_NORMAL: begin
          res.has_result = (item_byte != escape_byte);
          res.data       = item_byte;
        end
        MODE_ESCAPE: begin
          res.has_result = (item_byte != CH_X);
          case (item_byte)
            CH_N:    res.data = CODE_LF;
            CH_F:    res.data = CODE_FF;
            CH_R:    res.data = CODE_CR;
            CH_T:    res.data = CODE_TAB;
            CODE_LF: res.data = CODE_NUL;
            default: res.data = item_byte;
          endcase
        end
        MODE_HEX1: begin
          res.has_result = 1'b0;
        end
        MODE_HEX2: begin
          res.has_result = 1'b1;
          if (first_hex) begin
            res.data = hex[4] ? {first_value, hex[3:0]} : {4'd0, first_value};
          end
        end
        default: res.has_result = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      first_value <= 4'd0;
      first_hex   <= 1'b0;
    end else if (item_valid && advance) begin
      mode        <= mode_next;
      first_value <= first_value_next;
      first_hex   <= first_hex_next;
    end
  end

endmodule

// ----- src/escdec_out_stage.sv -----
module escdec_out_stage import escdec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    res,
  output logic       space,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind
);

  logic       valid;
  logic [7:0] data;
  kind_t      code;

  assign space     = !valid || out_ready;
  assign out_valid = valid;
  assign out_byte  = data;
  assign kind      = code;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res.data;
      code <= res.kind;
    end
  end

endmodule

// ----- src/escape_sequence_decoder.sv -----
// escape sequence decoder
// input channel: in_valid/in_ready carry one item per handshake, either a raw
// byte (in_byte) or an end-of-stream mark (at_end high, in_byte ignored)
// output channel: out_valid/out_ready carry one decoded item: out_byte with
// kind 0 for a character, kind 1 for a clean end, kind 2 for an end inside
// an escape sequence (out_byte is 0 for both end kinds)
// the escape byte, the x and the first hex digit give no output item
// config channel: cfg_valid/cfg_ready write the escape byte from cfg_data;
// cfg_ready is always high, write only while no item is in flight
// path: an item enters the input register at its accepting edge, is decoded
// combinationally from there, and its result is loaded into the output
// register, which drives out_valid
// throughput: one item per cycle while the output stage has space, set by the
// single decode step between the input register and the output register
// when the receiver stalls the result is held, one more item waits in the
// input register, then in_ready drops
// reset: escape byte back to backslash, decoder in normal mode, both
// registers empty
module escape_sequence_decoder import escdec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       at_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] escape_byte;
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_end;
  logic       advance;
  logic       space;
  logic       load;
  result_t    res;
  status_t    status;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && (!res.has_result || space);
  assign load      = advance && res.has_result;
  assign in_ready  = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_byte <= ESCAPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      escape_byte <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= in_byte;
      stage_end  <= at_end;
    end
  end

  escdec_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .escape_byte (escape_byte),
    .item_valid  (stage_valid),
    .item_byte   (stage_byte),
    .item_end    (stage_end),
    .advance     (advance),
    .res         (res),
    .status      (status)
  );

  escdec_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .kind      (kind)
  );

  a_end_clears_mode: assert property (@(posedge clk) disable iff (rst)
    advance && stage_end |=> status.mode == MODE_NORMAL)
    else $error("end item left decoder outside normal mode");

  a_end_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_CHAR |-> out_byte == 8'd0)
    else $error("end item carries a nonzero byte");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !load)
    else $error("held result overwritten");

endmodule
